### rtl/aes_pkg.sv
// ---------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte-level functions for the AES-128 core.
// ---------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUNDS_DEFAULT = 10;
    localparam int CFG_IDX_W      = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_ENCRYPT = 1'b0,
        KIND_DECRYPT = 1'b1
    } kind_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // take a new block, add the first round key
        logic do_round;   // run one middle or final round
        logic last_round; // no mix columns in this round
        logic key_start;  // load key halves into the expansion registers
        logic key_step;   // derive next round key
    } aes_cmd_t;

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        sbox = t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
        inv_sbox = t[a];
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] b0, b1, b2, b3;
        b0 = c[31:24]; b1 = c[23:16]; b2 = c[15:8]; b3 = c[7:0];
        mix_col = {xtime(b0) ^ xtime(b1) ^ b1 ^ b2 ^ b3,
                   b0 ^ xtime(b1) ^ xtime(b2) ^ b2 ^ b3,
                   b0 ^ b1 ^ xtime(b2) ^ xtime(b3) ^ b3,
                   xtime(b0) ^ b0 ^ b1 ^ b2 ^ xtime(b3)};
    endfunction

    // inverse mix via pre-multiply by {05,00,04,00} then forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] b0, b1, b2, b3, u, v;
        b0 = c[31:24]; b1 = c[23:16]; b2 = c[15:8]; b3 = c[7:0];
        u = xtime(xtime(b0 ^ b2));
        v = xtime(xtime(b1 ^ b3));
        inv_mix_col = mix_col({b0 ^ u, b1 ^ v, b2 ^ u, b3 ^ v});
    endfunction

endpackage

### rtl/aes_stream_if.sv
// ---------------------------------------------------------------------------
// aes_stream_if
// Valid/ready channel with a generic payload.
// ---------------------------------------------------------------------------
interface aes_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/aes_ctrl.sv
// ---------------------------------------------------------------------------
// aes_ctrl
// Sequencer for key expansion and round iteration.
// ---------------------------------------------------------------------------
module aes_ctrl
    import aes_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     key_write,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output aes_cmd_t cmd
);
    localparam int CNT_W = $clog2(ROUNDS + 1);

    typedef enum logic [3:0] {
        ST_KEY   = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               key_start_reg, key_start_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_KEY;
            cnt_reg       <= '0;
            key_start_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            key_start_reg <= key_start_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        // a pending key request is held until the schedule restarts
        key_start_next = key_write || (key_start_reg && state_reg != ST_KEY);
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_KEY:
            begin
                // forward expansion walks the key schedule to the last round
                if (key_start_reg)
                begin
                    cmd.key_start = 1'b1;
                    cnt_next      = '0;
                end
                else if (cnt_reg == CNT_W'(ROUNDS))
                    state_next = ST_IDLE;
                else
                begin
                    cmd.key_step = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = !key_write && !key_start_reg;
                if (key_start_reg)
                    state_next = ST_KEY;
                else if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.do_round   = 1'b1;
                cmd.last_round = (cnt_reg == CNT_W'(ROUNDS));
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROUNDS))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_KEY;
        endcase
    end
endmodule

### rtl/aes_datapath.sv
// ---------------------------------------------------------------------------
// aes_datapath
// Round-iterative state register, round key memory and key schedule.
// ---------------------------------------------------------------------------
module aes_datapath
    import aes_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [63:0]    key_high,
    input  logic [63:0]    key_low,
    input  logic           kind,
    input  logic [127:0]   block,
    input  aes_cmd_t       cmd,
    output logic [127:0]   result
);
    localparam int CNT_W = $clog2(ROUNDS + 1);

    logic [127:0]     rk_mem [ROUNDS+1];
    logic [127:0]     rk_reg, rk_next;
    logic [7:0]       rcon_reg;
    logic [CNT_W-1:0] wr_idx_reg;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [127:0]     rk_rd_reg;
    logic [127:0]     st_reg, st_next;
    logic             dec_reg;

    // key schedule step
    always_comb
    begin
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = rk_reg[31:0];
        t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
            ^ {rcon_reg, 24'h0};
        w0 = rk_reg[127:96] ^ t;
        w1 = rk_reg[95:64] ^ w0;
        w2 = rk_reg[63:32] ^ w1;
        w3 = rk_reg[31:0] ^ w2;
        rk_next = {w0, w1, w2, w3};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcon_reg   <= 8'h01;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            dec_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.key_start)
            begin
                rcon_reg   <= 8'h01;
                wr_idx_reg <= '0;
            end
            else if (cmd.key_step)
            begin
                rcon_reg   <= xtime(rcon_reg);
                wr_idx_reg <= wr_idx_reg + 1'b1;
            end
            rd_idx_reg <= rd_idx_next;
            if (cmd.load)
                dec_reg <= kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_start)
            rk_reg <= {key_high, key_low};
        else if (cmd.key_step)
            rk_reg <= rk_next;
        if (cmd.key_start)
            rk_mem[0] <= {key_high, key_low};
        else if (cmd.key_step)
            rk_mem[wr_idx_reg + 1'b1] <= rk_next;
        rk_rd_reg <= rk_mem[rd_idx_next];
    end

    // prefetch the key for the round that follows
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.load)
            rd_idx_next = (kind == KIND_DECRYPT) ? CNT_W'(ROUNDS - 1) : CNT_W'(1);
        else if (cmd.do_round)
            rd_idx_next = dec_reg ? rd_idx_reg - 1'b1 : rd_idx_reg + 1'b1;
    end

    // first key at load: the cipher key itself, or the last schedule word group
    // which stays in the expansion register once the schedule is done
    logic [127:0] first_key;
    assign first_key = (kind == KIND_DECRYPT) ? rk_reg : {key_high, key_low};

    always_comb
    begin
        logic [7:0]  s  [16];
        logic [7:0]  t  [16];
        logic [127:0] v;
        for (int n = 0; n < 16; n++)
            s[n] = st_reg[127 - 8*n -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (dec_reg)
                    t[((c + r) % 4) * 4 + r] = inv_sbox(s[c*4 + r]);
                else
                    t[c*4 + r] = sbox(s[((c + r) % 4) * 4 + r]);
        for (int n = 0; n < 16; n++)
            v[127 - 8*n -: 8] = t[n];
        if (dec_reg)
        begin
            v = v ^ rk_rd_reg;
            if (!cmd.last_round)
                for (int c = 0; c < 4; c++)
                    v[127 - 32*c -: 32] = inv_mix_col(v[127 - 32*c -: 32]);
        end
        else
        begin
            if (!cmd.last_round)
                for (int c = 0; c < 4; c++)
                    v[127 - 32*c -: 32] = mix_col(v[127 - 32*c -: 32]);
            v = v ^ rk_rd_reg;
        end
        st_next = st_reg;
        if (cmd.load)
            st_next = block ^ first_key;
        else if (cmd.do_round)
            st_next = v;
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign result = st_reg;
endmodule

### rtl/aes128_block_cipher_core.sv
// ---------------------------------------------------------------------------
// aes128_block_cipher_core
// AES-128 block engine, one round per cycle, encrypt and decrypt.
// ---------------------------------------------------------------------------
// usage:
//   cfg  : write transactions, index 0 = key_high, 1 = key_low; any write to
//          either register re-expands the key; other indexes are ignored
//   in   : one transaction = kind (0 encrypt, 1 decrypt) and a 128-bit block
//   out  : one transaction per input with the transformed block
// timing:
//   an accepted block gets the initial key addition and then ten rounds,
//   one round per cycle through the shared round unit, and then waits in the
//   state register until taken; the next block is accepted only after that
//   transaction, so a new block is never taken while one is in flight
//   a key write re-runs the key schedule, during which no block is accepted;
//   the schedule also runs once after reset (all-zero key)
// stalls:
//   while out.ready is low the result holds and no new block is taken
// ---------------------------------------------------------------------------
module aes128_block_cipher_core
    import aes_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    aes_stream_if.sink   cfg,
    aes_stream_if.sink   in,
    aes_stream_if.source out
);
    aes_cmd_t     cmd;
    logic [63:0]  key_high_reg, key_low_reg;
    logic         key_write;
    logic [127:0] result;

    assign cfg.ready = 1'b1;
    assign key_write = cfg.valid && (cfg.data.index == REG_KEY_HIGH
                                     || cfg.data.index == REG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.index == REG_KEY_HIGH)
                key_high_reg <= cfg.data.value;
            else if (cfg.data.index == REG_KEY_LOW)
                key_low_reg <= cfg.data.value;
        end
    end

    aes_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_write (key_write),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .cmd       (cmd)
    );

    aes_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .kind     (in.data.kind),
        .block    ({in.data.block_high, in.data.block_low}),
        .cmd      (cmd),
        .result   (result)
    );

    assign out.data.result_high = result[127:64];
    assign out.data.result_low  = result[63:0];
endmodule
